>>> src/mtcx_pkg.sv
// ----------------------------------------------------------------------------
// mtcx_pkg
// Shared types and constants of the MT19937 keystream decryptor.
// ----------------------------------------------------------------------------
package mtcx_pkg;

	localparam int unsigned MtN   = 624;
	localparam int unsigned MtM   = 397;
	localparam int unsigned IdxW  = 10;
	localparam int unsigned WordW = 32;

	localparam logic [IdxW-1:0] IdxLast  = IdxW'(MtN - 1);
	localparam logic [IdxW:0]   FarOffs  = (IdxW+1)'(MtM);
	localparam logic [IdxW:0]   NWide    = (IdxW+1)'(MtN);

	localparam logic [WordW-1:0] MtMatrix   = 32'h9908_B0DF;
	localparam logic [WordW-1:0] MtInitMult = 32'h6C07_8965;
	localparam logic [WordW-1:0] TemperB    = 32'h9D2C_5680;
	localparam logic [WordW-1:0] TemperC    = 32'hEFC6_0000;
	localparam logic [WordW-1:0] ChainInit  = 32'h4341_5046;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SEED,
		ST_RD0,
		ST_RD1,
		ST_RD2,
		ST_CALC
	} mtcx_state_t;

	typedef enum logic [1:0] {
		RD_POS,
		RD_NEXT,
		RD_FAR
	} mtcx_rd_sel_t;

	typedef struct packed {
		logic         load;
		logic         seed_init;
		logic         seed_step;
		logic         rd_en;
		mtcx_rd_sel_t rd_sel;
		logic         lat_cur;
		logic         lat_nxt;
		logic         commit;
	} mtcx_cmd_t;

	typedef struct packed {
		logic seeded;
		logic seed_last;
		logic out_free;
	} mtcx_status_t;

endpackage

>>> src/mtcx_ctrl.sv
// ----------------------------------------------------------------------------
// mtcx_ctrl
// Sequencer: accepts one word, seeds the state memory when needed, then
// steps the three state reads and the final twist-temper-xor commit.
// ----------------------------------------------------------------------------
module mtcx_ctrl
	import mtcx_pkg::*;
(
	input  logic         clk,
	input  logic         arst_n,
	input  logic         in_valid,
	input  logic         in_start,
	output logic         in_ready,
	input  mtcx_status_t status,
	output mtcx_cmd_t    cmd
);

	mtcx_state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d       = state_q;
		in_ready      = 1'b0;
		cmd.load      = 1'b0;
		cmd.seed_init = 1'b0;
		cmd.seed_step = 1'b0;
		cmd.rd_en     = 1'b0;
		cmd.rd_sel    = RD_POS;
		cmd.lat_cur   = 1'b0;
		cmd.lat_nxt   = 1'b0;
		cmd.commit    = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.load = 1'b1;
					if (in_start || !status.seeded) begin
						cmd.seed_init = 1'b1;
						state_d       = ST_SEED;
					end else begin
						state_d = ST_RD0;
					end
				end
			end
			ST_SEED: begin
				cmd.seed_step = 1'b1;
				if (status.seed_last) begin
					state_d = ST_RD0;
				end
			end
			ST_RD0: begin
				cmd.rd_en  = 1'b1;
				cmd.rd_sel = RD_POS;
				state_d    = ST_RD1;
			end
			ST_RD1: begin
				cmd.rd_en   = 1'b1;
				cmd.rd_sel  = RD_NEXT;
				cmd.lat_cur = 1'b1;
				state_d     = ST_RD2;
			end
			ST_RD2: begin
				cmd.rd_en   = 1'b1;
				cmd.rd_sel  = RD_FAR;
				cmd.lat_nxt = 1'b1;
				state_d     = ST_CALC;
			end
			ST_CALC: begin
				if (status.out_free) begin
					cmd.commit = 1'b1;
					state_d    = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

endmodule

>>> src/mtcx_dpath.sv
// ----------------------------------------------------------------------------
// mtcx_dpath
// Datapath: seed register, 624-word generator state memory, seeding
// multiplier, lazy per-word twist, tempering, chain and output register.
// ----------------------------------------------------------------------------
module mtcx_dpath
	import mtcx_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic             cfg_we,
	input  logic [WordW-1:0] cfg_word,
	input  logic [WordW-1:0] cipher_word,
	input  mtcx_cmd_t        cmd,
	output mtcx_status_t     status,
	output logic             out_valid,
	input  logic             out_ready,
	output logic [WordW-1:0] plain_word
);

	logic [WordW-1:0] gen_mem [0:MtN-1];

	logic [WordW-1:0] key_seed_q;
	logic [WordW-1:0] cipher_q;
	logic [WordW-1:0] chain_q;
	logic [IdxW-1:0]  pos_q;
	logic             seeded_q;
	logic [WordW-1:0] seed_val_q;
	logic [IdxW-1:0]  seed_idx_q;
	logic [WordW-1:0] rdata_q;
	logic [WordW-1:0] cur_q;
	logic [WordW-1:0] nxt_q;
	logic             out_valid_q;
	logic [WordW-1:0] out_data_q;

	logic [IdxW-1:0]  pos_next;
	logic [IdxW:0]    far_sum;
	logic [IdxW-1:0]  pos_far;
	logic [IdxW-1:0]  raddr;
	logic [IdxW-1:0]  seed_idx_inc;
	logic [WordW-1:0] seed_mix;
	logic [WordW-1:0] seed_next;
	logic [WordW-1:0] twist_y;
	logic [WordW-1:0] twist_v;
	logic [WordW-1:0] tmp1, tmp2, tmp3, key_word;
	logic [WordW-1:0] chain_new;
	logic             mem_we;
	logic [IdxW-1:0]  mem_waddr;
	logic [WordW-1:0] mem_wdata;

	assign pos_next = (pos_q == IdxLast) ? '0 : pos_q + 1'b1;
	assign far_sum  = {1'b0, pos_q} + FarOffs;
	assign pos_far  = (far_sum >= NWide) ? IdxW'(far_sum - NWide) : far_sum[IdxW-1:0];

	always_comb begin
		unique case (cmd.rd_sel)
			RD_POS:  raddr = pos_q;
			RD_NEXT: raddr = pos_next;
			RD_FAR:  raddr = pos_far;
			default: raddr = pos_q;
		endcase
	end

	assign seed_idx_inc = seed_idx_q + 1'b1;
	assign seed_mix     = seed_val_q ^ (seed_val_q >> 30);
	assign seed_next    = WordW'(MtInitMult * seed_mix) + {{(WordW-IdxW){1'b0}}, seed_idx_inc};

	assign twist_y  = {cur_q[WordW-1], nxt_q[WordW-2:0]};
	assign twist_v  = rdata_q ^ (twist_y >> 1) ^ (twist_y[0] ? MtMatrix : '0);
	assign tmp1     = twist_v ^ (twist_v >> 11);
	assign tmp2     = tmp1 ^ ((tmp1 << 7) & TemperB);
	assign tmp3     = tmp2 ^ ((tmp2 << 15) & TemperC);
	assign key_word = tmp3 ^ (tmp3 >> 18);
	assign chain_new = chain_q ^ cipher_q ^ key_word;

	assign mem_we    = cmd.seed_step || cmd.commit;
	assign mem_waddr = cmd.seed_step ? seed_idx_q : pos_q;
	assign mem_wdata = cmd.seed_step ? seed_val_q : twist_v;

	always_ff @(posedge clk) begin
		if (mem_we) begin
			gen_mem[mem_waddr] <= mem_wdata;
		end
		if (cmd.rd_en) begin
			rdata_q <= gen_mem[raddr];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			cipher_q <= cipher_word;
		end
		if (cmd.seed_init) begin
			seed_val_q <= key_seed_q;
		end else if (cmd.seed_step) begin
			seed_val_q <= seed_next;
		end
		if (cmd.lat_cur) begin
			cur_q <= rdata_q;
		end
		if (cmd.lat_nxt) begin
			nxt_q <= rdata_q;
		end
		if (cmd.commit) begin
			out_data_q <= chain_new;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key_seed_q  <= '0;
			chain_q     <= ChainInit;
			pos_q       <= '0;
			seeded_q    <= 1'b0;
			seed_idx_q  <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				key_seed_q <= cfg_word;
			end
			if (cmd.seed_init) begin
				chain_q    <= ChainInit;
				pos_q      <= '0;
				seeded_q   <= 1'b1;
				seed_idx_q <= '0;
			end else begin
				if (cmd.seed_step) begin
					seed_idx_q <= seed_idx_inc;
				end
				if (cmd.commit) begin
					chain_q <= chain_new;
					pos_q   <= pos_next;
				end
			end
			if (cmd.commit) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign status.seeded    = seeded_q;
	assign status.seed_last = (seed_idx_q == IdxLast);
	assign status.out_free  = !out_valid_q || out_ready;

	assign out_valid  = out_valid_q;
	assign plain_word = out_data_q;

endmodule

>>> src/mt19937_chained_xor_decrypt.sv
// ----------------------------------------------------------------------------
// mt19937_chained_xor_decrypt
// Decrypts 32-bit words with a chained MT19937 keystream.
// ----------------------------------------------------------------------------
// The slave stream carries one encrypted word per transaction; tuser marks
// the first word of a file. The master stream returns one decrypted word
// per accepted word, in order. The seed is written through the cfg channel,
// which is always ready, and takes effect at the next start of file.
// An ordinary word, once accepted, passes the states RD0, RD1 and RD2,
// which read the state memory three times (current, next and far
// element), before the twist, tempering and chain update are committed
// together to the result register in CALC. A word that starts a file,
// and the first word after reset, first seeds the 624 state elements,
// one per cycle through the seeding multiplier. The block works on one
// word at a time; a new word is accepted while the previous result still
// waits in the output register. When the receiver stalls, the next result
// is held back until the output register frees up. Reset clears the seed
// to zero and forces the next word to reseed.
// ----------------------------------------------------------------------------
module mt19937_chained_xor_decrypt
	import mtcx_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [31:0] s_tdata,   // [31:0] cipher_word
	input  logic [0:0]  s_tuser,   // [0] start_of_file
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [31:0] m_tdata,   // [31:0] plain_word
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [31:0] cfg_data
);

	mtcx_cmd_t    cmd;
	mtcx_status_t status;

	assign cfg_ready = 1'b1;

	mtcx_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_tvalid),
		.in_start (s_tuser[0]),
		.in_ready (s_tready),
		.status   (status),
		.cmd      (cmd)
	);

	mtcx_dpath u_dpath (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_we      (cfg_valid),
		.cfg_word    (cfg_data),
		.cipher_word (s_tdata),
		.cmd         (cmd),
		.status      (status),
		.out_valid   (m_tvalid),
		.out_ready   (m_tready),
		.plain_word  (m_tdata)
	);

endmodule

>>> src/mtcx_checker.sv
// ----------------------------------------------------------------------------
// mtcx_props
// Port-level checks of the decryptor, bound to the top level.
// ----------------------------------------------------------------------------
module mtcx_props (
	input logic        clk,
	input logic        arst_n,
	input logic        s_tvalid,
	input logic        s_tready,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [31:0] m_tdata,
	input logic        cfg_valid,
	input logic        cfg_ready
);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid)
		else $error("Result withdrawn while stalled.");

	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> $stable(m_tdata))
		else $error("Result changed while stalled.");

	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("Second word accepted while one is in work.");

	a_min_latency: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready && !m_tvalid |=> !m_tvalid)
		else $error("Result appeared too early.");

	a_cfg_ready: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_valid |-> cfg_ready)
		else $error("Configuration channel stalled.");

endmodule

bind mt19937_chained_xor_decrypt mtcx_props u_mtcx_props (.*);

>>> dv/mtcx_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mtcx_checker
// Predicts and checks the decrypted words of the MT19937 keystream decryptor.
// ----------------------------------------------------------------------------
// Every transaction on the cfg and slave channels updates a private copy of
// the seed, generator state, position and chain. Each accepted slave word
// yields one expected plain word, and each master transaction is compared
// with the oldest of them. The failure count and the number of words still
// outstanding go to the testbench top.
// ----------------------------------------------------------------------------
module mtcx_checker
	import mtcx_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	input  logic        s_tready,
	input  logic [31:0] s_tdata,
	input  logic [0:0]  s_tuser,
	input  logic        m_tvalid,
	input  logic        m_tready,
	input  logic [31:0] m_tdata,
	input  logic        cfg_valid,
	input  logic        cfg_ready,
	input  logic [31:0] cfg_data,
	output int          fail_count,
	output int          pending_count
);

	logic [WordW-1:0] seed_reg = '0;
	logic [WordW-1:0] mt_state [MtN];
	logic [IdxW-1:0]  word_pos = '0;
	logic [WordW-1:0] chain_reg = ChainInit;
	logic             is_seeded = 1'b0;
	logic [WordW-1:0] plain_expected [$];

	initial begin
		fail_count = 0;
		pending_count = 0;
	end

	function automatic logic [WordW-1:0] temper_word(input logic [WordW-1:0] w);
		logic [WordW-1:0] y;
		y = w ^ (w >> 11);
		y = y ^ ((y << 7) & TemperB);
		y = y ^ ((y << 15) & TemperC);
		y = y ^ (y >> 18);
		return y;
	endfunction

	task automatic load_seed(input logic [WordW-1:0] seed);
		logic [WordW-1:0] prev;
		mt_state[0] = seed;
		for (int k = 1; k < MtN; k++) begin
			prev = mt_state[k-1];
			mt_state[k] = MtInitMult * (prev ^ (prev >> 30)) + WordW'(k);
		end
	endtask

	task automatic regenerate_state();
		logic [WordW-1:0] y;
		logic [WordW-1:0] v;
		for (int k = 0; k < MtN; k++) begin
			y = {mt_state[k][WordW-1], mt_state[(k + 1) % MtN][WordW-2:0]};
			v = mt_state[(k + MtM) % MtN] ^ (y >> 1);
			if (y[0]) begin
				v = v ^ MtMatrix;
			end
			mt_state[k] = v;
		end
	endtask

	// A start of file, or the first word after reset, reseeds before the word is used.
	task automatic decrypt_word(input logic [WordW-1:0] cipher, input logic sof,
			output logic [WordW-1:0] plain);
		if (sof || !is_seeded) begin
			load_seed(seed_reg);
			word_pos = '0;
			chain_reg = ChainInit;
			is_seeded = 1'b1;
		end
		if (word_pos == '0) begin
			regenerate_state();
		end
		chain_reg = chain_reg ^ cipher ^ temper_word(mt_state[word_pos]);
		word_pos = (word_pos == IdxLast) ? '0 : word_pos + 1'b1;
		plain = chain_reg;
	endtask

	always @(posedge clk) begin : monitor
		logic [WordW-1:0] plain;
		logic [WordW-1:0] expected;
		if (!arst_n) begin
			seed_reg = '0;
			word_pos = '0;
			chain_reg = ChainInit;
			is_seeded = 1'b0;
			plain_expected.delete();
		end else begin
			if (cfg_valid && cfg_ready) begin
				seed_reg = cfg_data;
			end
			if (s_tvalid && s_tready) begin
				decrypt_word(s_tdata, s_tuser[0], plain);
				plain_expected.push_back(plain);
			end
			if (m_tvalid && m_tready) begin
				if (plain_expected.size() == 0) begin
					fail_count++;
					if (fail_count <= 10) begin
						$display("%0t: unexpected plain_word %h", $realtime, m_tdata);
					end
				end else begin
					expected = plain_expected.pop_front();
					if (m_tdata !== expected) begin
						fail_count++;
						if (fail_count <= 10) begin
							$display("%0t: plain_word mismatch: expected %h, got %h",
								$realtime, expected, m_tdata);
						end
					end
				end
			end
		end
		pending_count = plain_expected.size();
	end

endmodule

>>> dv/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Stimulus and verdict for the MT19937 keystream decryptor.
// ----------------------------------------------------------------------------
// A short directed sequence covers the seeding of the first word after
// reset, extreme words, a seed change inside a file and start flags on
// later words. Random files of mixed length follow in three phases with
// different idle rates on both streams, seed changes between files, and
// one long receiver hold-off. The checker beside the block reports the
// failures.
// ----------------------------------------------------------------------------
module testbench;

	localparam int CycleLimit = 800_000;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [31:0] s_tdata = '0;
	logic [0:0]  s_tuser = '0;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [31:0] m_tdata;
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic [31:0] cfg_data = '0;

	int   fail_count;
	int   pending_count;
	int   send_idle_pct = 14;
	int   recv_idle_pct = 52;
	logic hold_off = 1'b0;
	int   phase = 0;
	int   phase_sent = 0;
	int   cycle_count = 0;

	mt19937_chained_xor_decrypt u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_data  (cfg_data)
	);

	mtcx_checker u_checker (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_tvalid      (s_tvalid),
		.s_tready      (s_tready),
		.s_tdata       (s_tdata),
		.s_tuser       (s_tuser),
		.m_tvalid      (m_tvalid),
		.m_tready      (m_tready),
		.m_tdata       (m_tdata),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_data      (cfg_data),
		.fail_count    (fail_count),
		.pending_count (pending_count)
	);

	initial begin
		forever #1 clk = ~clk;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CycleLimit) begin
			$display("TEST FAILED");
			$finish;
		end
	end

	always @(posedge clk) begin
		if (hold_off) begin
			m_tready <= 1'b0;
		end else begin
			m_tready <= ($urandom_range(99) >= recv_idle_pct);
		end
	end

	// The receiver stalls long enough for the block to fill and back up the input.
	initial begin
		wait (phase == 3 && phase_sent >= 50);
		@(posedge clk);
		hold_off <= 1'b1;
		repeat (1000) @(posedge clk);
		hold_off <= 1'b0;
	end

	function automatic logic [31:0] pick_seed();
		case ($urandom_range(7))
			0: return 32'h0000_0000;
			1: return 32'hFFFF_FFFF;
			default: return $urandom;
		endcase
	endfunction

	task automatic send_word(input logic [31:0] cipher, input logic sof);
		while ($urandom_range(99) < send_idle_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= cipher;
		s_tuser <= sof;
		do @(posedge clk); while (!s_tready);
	endtask

	task automatic drain_results();
		s_tvalid <= 1'b0;
		do @(posedge clk); while (pending_count != 0);
		repeat (8) @(posedge clk);
	endtask

	task automatic write_seed(input logic [31:0] seed);
		cfg_valid <= 1'b1;
		cfg_data <= seed;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		@(posedge clk);
	endtask

	// Files mostly open with a start flag; a few continue the previous one,
	// and a few carry a stray start flag in the middle.
	task automatic run_files(input int n_items, input int first_len);
		int   left;
		int   len;
		int   r;
		logic sof;
		left = n_items;
		while (left > 0) begin
			r = $urandom_range(99);
			if (first_len > 0) begin
				len = first_len;
				first_len = 0;
			end else if (r < 80) begin
				len = $urandom_range(60, 1);
			end else if (r < 92) begin
				len = $urandom_range(700, 61);
			end else begin
				len = $urandom_range(1300, 620);
			end
			if (len > left) begin
				len = left;
			end
			if ($urandom_range(9) == 0) begin
				drain_results();
				write_seed(pick_seed());
			end
			for (int i = 0; i < len; i++) begin
				sof = (i == 0) ? ($urandom_range(9) != 0) : ($urandom_range(99) < 2);
				send_word($urandom, sof);
				phase_sent++;
			end
			left -= len;
		end
	endtask

	initial begin
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		phase = 1;

		send_word(32'h0000_0000, 1'b0);
		send_word(32'hFFFF_FFFF, 1'b0);
		send_word(32'hA5A5_A5A5, 1'b0);
		send_word(32'h5A5A_5A5A, 1'b0);
		drain_results();
		write_seed(32'hFFFF_FFFF);
		send_word(32'h1234_5678, 1'b0);
		send_word(32'h8000_0001, 1'b0);
		send_word(32'hFFFF_FFFF, 1'b1);
		send_word(32'h0000_0000, 1'b0);
		send_word(32'hDEAD_BEEF, 1'b0);
		send_word(32'h0000_0001, 1'b1);
		send_word(32'h7FFF_FFFF, 1'b0);
		drain_results();
		write_seed(32'h0000_0000);
		send_word(32'h0000_0000, 1'b1);
		send_word(32'hFFFF_FFFF, 1'b0);
		send_word(32'h0000_0001, 1'b1);
		send_word(32'h0000_0000, 1'b0);
		drain_results();

		write_seed(pick_seed());
		run_files(700, 640);
		drain_results();

		phase = 2;
		phase_sent = 0;
		send_idle_pct = 52;
		recv_idle_pct = 14;
		write_seed(pick_seed());
		run_files(575, 0);
		drain_results();

		phase = 3;
		phase_sent = 0;
		send_idle_pct = 0;
		recv_idle_pct = 0;
		write_seed($urandom);
		run_files(575, 0);
		drain_results();

		if (fail_count == 0 && pending_count == 0) begin
			$display("TEST PASSED");
		end else begin
			$display("TEST FAILED");
		end
		$finish;
	end

endmodule

>>> filelist.f
src/mtcx_pkg.sv
src/mtcx_ctrl.sv
src/mtcx_dpath.sv
src/mt19937_chained_xor_decrypt.sv
src/mtcx_checker.sv
dv/mtcx_checker.sv
dv/testbench.sv
